@@ rtl/core/ghpc_pkg.sv @@
// Shared types, constants and register codes for the grey histogram percentile cut block.
`default_nettype none
package ghpc_pkg;

  localparam int BIN_COUNT_DEF  = 256;
  localparam int COUNT_BITS_DEF = 22;
  localparam int GREY_W         = 8;
  localparam int PCT_W          = 14;
  localparam int INDEX_W        = 9;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int PCT_SCALE      = 10000;

  localparam logic [PCT_W-1:0] LOW_CUT_RESET  = 14'd0;
  localparam logic [PCT_W-1:0] HIGH_CUT_RESET = 14'd9900;

  localparam logic REG_LOW_CUT  = 1'b0;
  localparam logic REG_HIGH_CUT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_PIXEL,
    ST_DRAIN,
    ST_WALK,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic pix_accept;
    logic clear_en;
    logic walk_en;
    logic walk_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic pipe_busy;
  } stat_t;

endpackage
`default_nettype wire

@@ rtl/core/ghpc_ctrl.sv @@
// Controller state machine: pixel intake, clearing sweep, bin walk and result handoff.
`default_nettype none
module ghpc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          last_pixel_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  input  wire ghpc_pkg::stat_t stat_i,
  output ghpc_pkg::cmd_t     cmd_o
);

  ghpc_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             load;

  assign accept = in_valid_i && (state_q == ghpc_pkg::ST_PIXEL);
  assign load   = (state_q == ghpc_pkg::ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ghpc_pkg::ST_CLEAR: begin
        if (stat_i.sweep_last) state_d = ghpc_pkg::ST_PIXEL;
      end
      ghpc_pkg::ST_PIXEL: begin
        if (accept && last_pixel_i) state_d = ghpc_pkg::ST_DRAIN;
      end
      ghpc_pkg::ST_DRAIN: state_d = ghpc_pkg::ST_WALK;
      ghpc_pkg::ST_WALK: begin
        if (stat_i.sweep_last) state_d = ghpc_pkg::ST_FLUSH;
      end
      ghpc_pkg::ST_FLUSH: begin
        if (!stat_i.pipe_busy) state_d = ghpc_pkg::ST_DONE;
      end
      ghpc_pkg::ST_DONE: begin
        if (load) state_d = ghpc_pkg::ST_PIXEL;
      end
      default: state_d = ghpc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.pix_accept = accept;
    cmd_o.clear_en   = (state_q == ghpc_pkg::ST_CLEAR);
    cmd_o.walk_en    = (state_q == ghpc_pkg::ST_WALK);
    cmd_o.walk_start = (state_q == ghpc_pkg::ST_DRAIN);
    cmd_o.load_out   = load;
    in_stall_o       = (state_q != ghpc_pkg::ST_PIXEL);
    out_valid_o      = out_valid_q;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ghpc_pkg::ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/ghpc_datapath.sv @@
// Datapath: histogram memory with read-modify-write, pixel count, threshold walk and results.
`default_nettype none
module ghpc_datapath #(
  parameter int BIN_COUNT  = ghpc_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = ghpc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire ghpc_pkg::cmd_t                cmd_i,
  output ghpc_pkg::stat_t                    stat_o,
  input  wire logic [ghpc_pkg::GREY_W-1:0]   grey_level_i,
  input  wire logic [ghpc_pkg::PCT_W-1:0]    low_cut_i,
  input  wire logic [ghpc_pkg::PCT_W-1:0]    high_cut_i,
  output logic      [ghpc_pkg::INDEX_W-1:0]  black_index_o,
  output logic      [ghpc_pkg::INDEX_W-1:0]  white_index_o
);

  localparam int BIN_BITS = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int IDX_BITS = $clog2(BIN_COUNT + 1);
  localparam int GW1      = ghpc_pkg::GREY_W + 1;
  localparam int PW       = ghpc_pkg::PCT_W;
  localparam int NEED_W   = PW + COUNT_BITS;
  localparam int PROD_W   = COUNT_BITS + PW;
  localparam int SUM_W    = COUNT_BITS + BIN_BITS + PW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [PW-1:0]         SCALE     = PW'(ghpc_pkg::PCT_SCALE);

  logic [COUNT_BITS-1:0] mem [BIN_COUNT];

  logic [BIN_BITS-1:0]   pix_addr;
  logic [BIN_BITS-1:0]   rd_addr;
  logic [COUNT_BITS-1:0] rd_q;
  logic                  we;
  logic [BIN_BITS-1:0]   wa;
  logic [COUNT_BITS-1:0] wd;

  logic                  p_v_q;
  logic [BIN_BITS-1:0]   p_a_q;
  logic                  wv_q;
  logic [BIN_BITS-1:0]   wa_q;
  logic [COUNT_BITS-1:0] wd_q;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] inc;

  logic [COUNT_BITS-1:0] total_q;
  logic [BIN_BITS-1:0]   sweep_q;
  logic                  sweep_last;

  logic [PW-1:0]         low_mod;
  logic [PW-1:0]         high_mod;
  logic [NEED_W-1:0]     need_lo_q;
  logic [NEED_W-1:0]     need_hi_q;

  logic                  s1_q;
  logic [BIN_BITS-1:0]   k1_q;
  logic                  s2_q;
  logic [BIN_BITS-1:0]   k2_q;
  logic [PROD_W-1:0]     prod_q;
  logic [SUM_W-1:0]      ssum_q;
  logic                  done_lo_q;
  logic                  done_hi_q;
  logic [BIN_BITS-1:0]   idx_lo_q;
  logic [BIN_BITS-1:0]   idx_hi_q;
  logic [IDX_BITS-1:0]   res_lo;
  logic [IDX_BITS-1:0]   res_hi;
  logic [IDX_BITS-1:0]   black_q;
  logic [IDX_BITS-1:0]   white_q;

  assign pix_addr = (GW1'(grey_level_i) >= GW1'(BIN_COUNT)) ? BIN_BITS'(BIN_COUNT - 1)
                                                             : BIN_BITS'(grey_level_i);
  assign rd_addr  = cmd_i.walk_en ? sweep_q : pix_addr;

  assign cur = (wv_q && (wa_q == p_a_q)) ? wd_q : rd_q;
  assign inc = (cur == COUNT_MAX) ? COUNT_MAX : cur + COUNT_BITS'(1);

  always_comb begin
    we = 1'b0;
    wa = sweep_q;
    wd = '0;
    if (cmd_i.clear_en || cmd_i.walk_en) begin
      we = 1'b1;
    end else if (p_v_q) begin
      we = 1'b1;
      wa = p_a_q;
      wd = inc;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q   <= 1'b0;
      wv_q    <= 1'b0;
      total_q <= '0;
      sweep_q <= '0;
      s1_q    <= 1'b0;
      s2_q    <= 1'b0;
    end else begin
      p_v_q <= cmd_i.pix_accept;
      wv_q  <= p_v_q;
      if (cmd_i.walk_start) begin
        total_q <= '0;
      end else if (cmd_i.pix_accept && (total_q != COUNT_MAX)) begin
        total_q <= total_q + COUNT_BITS'(1);
      end
      if (cmd_i.clear_en || cmd_i.walk_en) begin
        sweep_q <= sweep_last ? '0 : sweep_q + BIN_BITS'(1);
      end
      s1_q <= cmd_i.walk_en;
      s2_q <= s1_q;
    end
  end

  assign sweep_last = (sweep_q == BIN_BITS'(BIN_COUNT - 1));

  always_ff @(posedge clk_i) begin
    p_a_q <= pix_addr;
    wa_q  <= p_a_q;
    wd_q  <= inc;
  end

  assign low_mod  = (low_cut_i >= SCALE) ? low_cut_i - SCALE : low_cut_i;
  assign high_mod = (high_cut_i >= SCALE) ? high_cut_i - SCALE : high_cut_i;

  always_ff @(posedge clk_i) begin
    k1_q   <= sweep_q;
    k2_q   <= k1_q;
    prod_q <= PROD_W'(rd_q) * PROD_W'(SCALE);
    if (cmd_i.walk_start) begin
      need_lo_q <= NEED_W'(low_mod) * NEED_W'(total_q);
      need_hi_q <= NEED_W'(high_mod) * NEED_W'(total_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssum_q    <= '0;
      done_lo_q <= 1'b0;
      done_hi_q <= 1'b0;
    end else if (cmd_i.walk_start) begin
      ssum_q    <= '0;
      done_lo_q <= 1'b0;
      done_hi_q <= 1'b0;
    end else if (s2_q) begin
      ssum_q <= ssum_q + SUM_W'(prod_q);
      if (!done_lo_q && (ssum_q >= SUM_W'(need_lo_q))) done_lo_q <= 1'b1;
      if (!done_hi_q && (ssum_q >= SUM_W'(need_hi_q))) done_hi_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_q && !done_lo_q && (ssum_q >= SUM_W'(need_lo_q))) idx_lo_q <= k2_q;
    if (s2_q && !done_hi_q && (ssum_q >= SUM_W'(need_hi_q))) idx_hi_q <= k2_q;
  end

  assign res_lo = done_lo_q ? IDX_BITS'(idx_lo_q) : IDX_BITS'(BIN_COUNT);
  assign res_hi = done_hi_q ? IDX_BITS'(idx_hi_q) : IDX_BITS'(BIN_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      black_q <= res_lo;
      white_q <= res_hi;
    end
  end

  assign black_index_o = ghpc_pkg::INDEX_W'(black_q);
  assign white_index_o = ghpc_pkg::INDEX_W'(white_q);

  assign stat_o.sweep_last = sweep_last;
  assign stat_o.pipe_busy  = s1_q || s2_q;

endmodule
`default_nettype wire

@@ rtl/core/grey_histogram_percentile_cuts.sv @@
// Top level: configuration registers and the controller and datapath of the percentile cut block.
// One pixel word per cycle while the input is not stalled; after the last pixel the input
// stalls (longer while the previous result word is stalled) as the bins are walked and cleared
// through one memory port, and the result word is then registered for output. After reset a
// clearing pass over all bins runs before the first pixel is taken; configuration writes are
// taken at any time.
`default_nettype none
module grey_histogram_percentile_cuts #(
  parameter int BIN_COUNT  = ghpc_pkg::BIN_COUNT_DEF,
  parameter int COUNT_BITS = ghpc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ghpc_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [ghpc_pkg::PDATA_W-1:0]  pwdata,
  output logic      [ghpc_pkg::PDATA_W-1:0]  prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [ghpc_pkg::GREY_W-1:0]   grey_level_i,
  input  wire logic                          last_pixel_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [ghpc_pkg::INDEX_W-1:0]  black_index_o,
  output logic      [ghpc_pkg::INDEX_W-1:0]  white_index_o
);

  logic [ghpc_pkg::PCT_W-1:0] low_cut_q;
  logic [ghpc_pkg::PCT_W-1:0] high_cut_q;
  logic                       reg_sel;
  logic                       wr_en;
  ghpc_pkg::cmd_t             cmd;
  ghpc_pkg::stat_t            stat;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_cut_q  <= ghpc_pkg::LOW_CUT_RESET;
      high_cut_q <= ghpc_pkg::HIGH_CUT_RESET;
    end else if (wr_en) begin
      case (reg_sel)
        ghpc_pkg::REG_LOW_CUT:  low_cut_q  <= pwdata[ghpc_pkg::PCT_W-1:0];
        ghpc_pkg::REG_HIGH_CUT: high_cut_q <= pwdata[ghpc_pkg::PCT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ghpc_pkg::REG_LOW_CUT:  prdata = ghpc_pkg::PDATA_W'(low_cut_q);
      ghpc_pkg::REG_HIGH_CUT: prdata = ghpc_pkg::PDATA_W'(high_cut_q);
      default:                prdata = '0;
    endcase
  end

  ghpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .last_pixel_i (last_pixel_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  ghpc_datapath #(
    .BIN_COUNT  (BIN_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .grey_level_i  (grey_level_i),
    .low_cut_i     (low_cut_q),
    .high_cut_i    (high_cut_q),
    .black_index_o (black_index_o),
    .white_index_o (white_index_o)
  );

endmodule
`default_nettype wire
